[rtl/tdcr_pkg.sv]
// Shared constants, types and register codes of the time-of-day colour ramp.
package tdcr_pkg;

  localparam int CHANNEL_BITS       = 8;
  localparam int HOUR_FRACTION_BITS = 8;
  localparam int HOUR_W             = 5 + HOUR_FRACTION_BITS;
  localparam int COLOUR_W           = 4 * CHANNEL_BITS;
  localparam int NUM_CHANNELS       = 4;

  // ramp factor in Q1.8, 0..256 inclusive
  localparam int FACTOR_BITS = 8;
  localparam int FACTOR_W    = FACTOR_BITS + 1;

  // restoring divider: one quotient bit per step
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = (FACTOR_W + DIV_STEPS - 1) / DIV_STEPS;

  localparam int PHASE_W      = 3;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = (COLOUR_W > HOUR_W) ? COLOUR_W : HOUR_W;
  localparam int IN_DATA_W    = ((HOUR_W + 7) / 8) * 8;
  localparam int OUT_DATA_W   = ((COLOUR_W + 7) / 8) * 8;

  typedef logic [HOUR_W-1:0]       hour_t;
  typedef logic [HOUR_W:0]         hour2_t;
  typedef logic [COLOUR_W-1:0]     colour_t;
  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [FACTOR_W-1:0]     factor_t;

  localparam factor_t FACTOR_ONE  = factor_t'(1 << FACTOR_BITS);
  localparam factor_t FACTOR_HALF = factor_t'(1 << (FACTOR_BITS - 1));

  localparam hour_t RST_SUNRISE_BEGIN  = hour_t'(5  << HOUR_FRACTION_BITS);
  localparam hour_t RST_SUNRISE_END    = hour_t'(8  << HOUR_FRACTION_BITS);
  localparam hour_t RST_SUNSET_BEGIN   = hour_t'(17 << HOUR_FRACTION_BITS);
  localparam hour_t RST_SUNSET_FINISH  = hour_t'(20 << HOUR_FRACTION_BITS);

  typedef enum logic [PHASE_W-1:0] {
    PH_NIGHT     = 3'd0,
    PH_SUNRISE   = 3'd1,
    PH_DAY       = 3'd2,
    PH_SUNSET    = 3'd3,
    PH_UNCOVERED = 3'd4
  } phase_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SUNRISE_BEGIN  = 3'd0,
    REG_SUNRISE_END    = 3'd1,
    REG_SUNSET_BEGIN   = 3'd2,
    REG_SUNSET_FINISH  = 3'd3,
    REG_NIGHT_COLOUR   = 3'd4,
    REG_SUNRISE_COLOUR = 3'd5,
    REG_DAY_COLOUR     = 3'd6,
    REG_SUNSET_COLOUR  = 3'd7
  } reg_index_t;

  typedef struct packed {
    hour_t   sunrise_begin;
    hour_t   sunrise_end;
    hour_t   sunset_begin;
    hour_t   sunset_finish;
    colour_t night_colour;
    colour_t sunrise_colour;
    colour_t day_colour;
    colour_t sunset_colour;
  } cfg_t;

  // word moving through the divider stages
  typedef struct packed {
    phase_t  phase;
    colour_t peak;
    colour_t other;
    hour_t   dur;
    hour2_t  rem;
    factor_t quot;
  } div_word_t;

  typedef struct packed {
    phase_t phase;
    chan_t  alpha;
    chan_t  blue;
    chan_t  green;
    chan_t  red;
  } result_t;

endpackage

[rtl/tdcr_select.sv]
// First stage: phase decode, window pick, midpoint distance and window length.
module tdcr_select import tdcr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  hour_t     in_hour,
  output logic      out_valid,
  input  logic      out_ready,
  output div_word_t out_word
);

  logic      valid_r;
  div_word_t word_r, word_nxt;

  logic    in_win;
  phase_t  phase;
  hour_t   win_b, win_e, dur_raw;
  colour_t peak, prev_col, next_col, flat;
  hour2_t  twice, sum, diff;
  logic    early;

  always_comb begin
    in_win   = 1'b0;
    phase    = PH_UNCOVERED;
    flat     = '0;
    win_b    = cfg.sunrise_begin;
    win_e    = cfg.sunrise_end;
    peak     = cfg.sunrise_colour;
    prev_col = cfg.night_colour;
    next_col = cfg.day_colour;
    if (in_hour < cfg.sunrise_begin || in_hour > cfg.sunset_finish) begin
      phase = PH_NIGHT;
      flat  = cfg.night_colour;
    end else if (in_hour >= cfg.sunrise_begin && in_hour <= cfg.sunrise_end) begin
      phase  = PH_SUNRISE;
      in_win = 1'b1;
    end else if (in_hour > cfg.sunrise_end && in_hour < cfg.sunset_begin) begin
      phase = PH_DAY;
      flat  = cfg.day_colour;
    end else if (in_hour >= cfg.sunset_begin && in_hour <= cfg.sunset_finish) begin
      phase    = PH_SUNSET;
      in_win   = 1'b1;
      win_b    = cfg.sunset_begin;
      win_e    = cfg.sunset_finish;
      peak     = cfg.sunset_colour;
      prev_col = cfg.day_colour;
      next_col = cfg.night_colour;
    end
  end

  assign twice   = {in_hour, 1'b0};
  assign sum     = {1'b0, win_b} + {1'b0, win_e};
  assign early   = (twice <= sum);
  assign diff    = early ? (sum - twice) : (twice - sum);
  assign dur_raw = win_e - win_b;

  // flat phases and zero-length windows: divide 0 by 1 so the factor is 0
  always_comb begin
    word_nxt.phase = phase;
    word_nxt.quot  = '0;
    if (in_win) begin
      word_nxt.peak  = peak;
      word_nxt.other = early ? prev_col : next_col;
      word_nxt.dur   = (dur_raw == '0) ? hour_t'(1) : dur_raw;
      word_nxt.rem   = (dur_raw == '0) ? '0 : diff;
    end else begin
      word_nxt.peak  = flat;
      word_nxt.other = flat;
      word_nxt.dur   = hour_t'(1);
      word_nxt.rem   = '0;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= word_nxt;
    end
  end

endmodule

[rtl/tdcr_div_stage.sv]
// One stage of the restoring divider: a few quotient bits of the ramp factor.
module tdcr_div_stage import tdcr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_word_t in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output div_word_t out_word
);

  logic      valid_r;
  div_word_t word_r, word_nxt;
  logic      qbit;

  // rem <= dur on entry to the first stage and rem < 2*dur after each step
  always_comb begin
    word_nxt = in_word;
    qbit     = 1'b0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      qbit          = (word_nxt.rem >= {1'b0, word_nxt.dur});
      word_nxt.quot = {word_nxt.quot[FACTOR_W-2:0], qbit};
      if (qbit) begin
        word_nxt.rem = (word_nxt.rem - {1'b0, word_nxt.dur}) << 1;
      end else begin
        word_nxt.rem = word_nxt.rem << 1;
      end
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= word_nxt;
    end
  end

endmodule

[rtl/tdcr_blend.sv]
// Last stage: per-channel blend of peak and neighbor colour, output register.
module tdcr_blend import tdcr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  div_word_t in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   out_res
);

  localparam int ACC_W = CHANNEL_BITS + FACTOR_W + 1;

  logic    valid_r;
  result_t res_r, res_nxt;

  factor_t                inv_f;
  chan_t                  pk  [NUM_CHANNELS];
  chan_t                  ot  [NUM_CHANNELS];
  logic [ACC_W-1:0]       acc [NUM_CHANNELS];
  chan_t                  ch  [NUM_CHANNELS];

  assign inv_f = FACTOR_ONE - in_word.quot;

  // channel 0 is red, taken from the top of the packed colour
  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      pk[c]  = in_word.peak[(NUM_CHANNELS-1-c)*CHANNEL_BITS +: CHANNEL_BITS];
      ot[c]  = in_word.other[(NUM_CHANNELS-1-c)*CHANNEL_BITS +: CHANNEL_BITS];
      acc[c] = ACC_W'(pk[c]) * ACC_W'(inv_f) + ACC_W'(ot[c]) * ACC_W'(in_word.quot)
             + ACC_W'(FACTOR_HALF);
      ch[c]  = acc[c][FACTOR_BITS +: CHANNEL_BITS];
    end
  end

  always_comb begin
    res_nxt.phase = in_word.phase;
    res_nxt.red   = ch[0];
    res_nxt.green = ch[1];
    res_nxt.blue  = ch[2];
    res_nxt.alpha = ch[3];
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_r <= res_nxt;
    end
  end

endmodule

[rtl/time_of_day_colour_ramp.sv]
// Top level of the time-of-day colour ramp: config registers and the pipeline.
//
// Each input word carries an hour of the day (unsigned, 8 fraction bits) and
// gives exactly one output word: a four-channel colour plus a phase code
// (0 night, 1 sunrise, 2 day, 3 sunset, 4 uncovered). Before the sunrise
// window and after the sunset window the night colour comes out, between
// the windows the day colour; inside a window the colour ramps from the
// neighbor colour to the window's peak colour at the midpoint and on to the
// next colour, with a Q1.8 factor 2*|hour - mid| / length and rounding half
// up. The block takes one word per clock unless the output stalls; it has
// one stage for phase decode and window arithmetic, three divider stages
// that each produce three bits of the factor, and one blend stage that also
// serves as the output register. Every stage has its own valid bit and
// holds its word under backpressure, so empty stages keep accepting while a
// result waits at the output. Write window edges and colours through the cfg
// port only while no word is in flight; the block does not enforce this.
module time_of_day_colour_ramp import tdcr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_DATA_W-1:0]   in_tdata,   // [12:0] hour, rest zero
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,  // red, green, blue, alpha (8 bits each, low up)
  output logic [PHASE_W-1:0]     out_tuser,  // [2:0] phase
  // config write port
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_SUNRISE_BEGIN:  cfg_nxt.sunrise_begin  = cfg_wdata[HOUR_W-1:0];
        REG_SUNRISE_END:    cfg_nxt.sunrise_end    = cfg_wdata[HOUR_W-1:0];
        REG_SUNSET_BEGIN:   cfg_nxt.sunset_begin   = cfg_wdata[HOUR_W-1:0];
        REG_SUNSET_FINISH:  cfg_nxt.sunset_finish  = cfg_wdata[HOUR_W-1:0];
        REG_NIGHT_COLOUR:   cfg_nxt.night_colour   = cfg_wdata[COLOUR_W-1:0];
        REG_SUNRISE_COLOUR: cfg_nxt.sunrise_colour = cfg_wdata[COLOUR_W-1:0];
        REG_DAY_COLOUR:     cfg_nxt.day_colour     = cfg_wdata[COLOUR_W-1:0];
        REG_SUNSET_COLOUR:  cfg_nxt.sunset_colour  = cfg_wdata[COLOUR_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sunrise_begin  <= RST_SUNRISE_BEGIN;
      cfg_r.sunrise_end    <= RST_SUNRISE_END;
      cfg_r.sunset_begin   <= RST_SUNSET_BEGIN;
      cfg_r.sunset_finish  <= RST_SUNSET_FINISH;
      cfg_r.night_colour   <= '0;
      cfg_r.sunrise_colour <= '0;
      cfg_r.day_colour     <= '0;
      cfg_r.sunset_colour  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // stage links: index 0 is the select stage output, last feeds the blend
  logic      link_valid [DIV_STAGES+1];
  logic      link_ready [DIV_STAGES+1];
  div_word_t link_word  [DIV_STAGES+1];
  result_t   res;

  tdcr_select u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_hour   (in_tdata[HOUR_W-1:0]),
    .out_valid (link_valid[0]),
    .out_ready (link_ready[0]),
    .out_word  (link_word[0])
  );

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    tdcr_div_stage u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (link_valid[s]),
      .in_ready  (link_ready[s]),
      .in_word   (link_word[s]),
      .out_valid (link_valid[s+1]),
      .out_ready (link_ready[s+1]),
      .out_word  (link_word[s+1])
    );
  end

  tdcr_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (link_valid[DIV_STAGES]),
    .in_ready  (link_ready[DIV_STAGES]),
    .in_word   (link_word[DIV_STAGES]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = OUT_DATA_W'({res.alpha, res.blue, res.green, res.red});
  assign out_tuser = res.phase;

endmodule

[verif/time_of_day_colour_ramp_test.sv]
// Self-checking stream testbench for the time-of-day colour ramp.
module time_of_day_colour_ramp_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tdcr_pkg::*;

  localparam int DAY_END      = 24 << HOUR_FRACTION_BITS;  // 24.0 h, end of the day; hours run up to HOUR_MAX
  localparam int HOUR_MAX     = (1 << HOUR_W) - 1;         // largest 13-bit hour
  localparam int PIPE_LATENCY = 5;
  localparam int HOLD_CYCLES  = 80;                        // long receiver hold-off
  localparam int TIMEOUT_NS   = 2_000_000;
  localparam logic [CFG_DATA_W-1:0] HOUR_PAD_BITS = ~CFG_DATA_W'((1 << HOUR_W) - 1);

  // Scoreboard: own copy of the registers, predicts one colour word per hour.
  class colour_ramp_checker;
    cfg_t    regs;
    result_t expected_q[$];
    int      errors;
    int      checked;
    int      phase_hits[5];

    function new();
      regs                = '0;
      regs.sunrise_begin  = RST_SUNRISE_BEGIN;
      regs.sunrise_end    = RST_SUNRISE_END;
      regs.sunset_begin   = RST_SUNSET_BEGIN;
      regs.sunset_finish  = RST_SUNSET_FINISH;
      errors  = 0;
      checked = 0;
      foreach (phase_hits[i]) phase_hits[i] = 0;
    endfunction

    // bits above the register width are dropped
    function void write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_SUNRISE_BEGIN:  regs.sunrise_begin  = value[HOUR_W-1:0];
        REG_SUNRISE_END:    regs.sunrise_end    = value[HOUR_W-1:0];
        REG_SUNSET_BEGIN:   regs.sunset_begin   = value[HOUR_W-1:0];
        REG_SUNSET_FINISH:  regs.sunset_finish  = value[HOUR_W-1:0];
        REG_NIGHT_COLOUR:   regs.night_colour   = value[COLOUR_W-1:0];
        REG_SUNRISE_COLOUR: regs.sunrise_colour = value[COLOUR_W-1:0];
        REG_DAY_COLOUR:     regs.day_colour     = value[COLOUR_W-1:0];
        REG_SUNSET_COLOUR:  regs.sunset_colour  = value[COLOUR_W-1:0];
        default: ;
      endcase
    endfunction

    // channel 0 is red in the top byte, alpha sits in the lowest byte
    function chan_t chan_of(colour_t col, int c);
      return col[(NUM_CHANNELS - 1 - c) * CHANNEL_BITS +: CHANNEL_BITS];
    endfunction

    function result_t solid(colour_t col, phase_t ph);
      result_t r;
      r.red   = chan_of(col, 0);
      r.green = chan_of(col, 1);
      r.blue  = chan_of(col, 2);
      r.alpha = chan_of(col, 3);
      r.phase = ph;
      return r;
    endfunction

    function result_t ramp_colour(int h, int b, int e, colour_t peak, colour_t prev_col,
                                  colour_t next_col, phase_t ph);
      result_t r;
      chan_t   ch[NUM_CHANNELS];
      colour_t other;
      int      unit, offset, len, f;
      bit      early;
      unit   = 1 << FACTOR_BITS;
      early  = (2 * h <= b + e);
      offset = early ? (b + e - 2 * h) : (2 * h - b - e);
      len    = e - b;
      if (len == 0) begin
        f = early ? 0 : unit;
      end else begin
        f = (offset << FACTOR_BITS) / len;
        if (f > unit) f = unit;
      end
      other = early ? prev_col : next_col;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        ch[c] = chan_t'((int'(chan_of(peak, c)) * (unit - f) + int'(chan_of(other, c)) * f
                         + unit / 2) >> FACTOR_BITS);
      end
      r.red   = ch[0];
      r.green = ch[1];
      r.blue  = ch[2];
      r.alpha = ch[3];
      r.phase = ph;
      return r;
    endfunction

    function result_t predict(hour_t hr);
      result_t r;
      int h, srb, srf, ssb, ssf;
      h   = hr;
      srb = regs.sunrise_begin;
      srf = regs.sunrise_end;
      ssb = regs.sunset_begin;
      ssf = regs.sunset_finish;
      // first matching rule wins
      if (h < srb || h > ssf) begin
        r = solid(regs.night_colour, PH_NIGHT);
      end else if (h >= srb && h <= srf) begin
        r = ramp_colour(h, srb, srf, regs.sunrise_colour, regs.night_colour, regs.day_colour,
                        PH_SUNRISE);
      end else if (h > srf && h < ssb) begin
        r = solid(regs.day_colour, PH_DAY);
      end else if (h >= ssb && h <= ssf) begin
        r = ramp_colour(h, ssb, ssf, regs.sunset_colour, regs.day_colour, regs.night_colour,
                        PH_SUNSET);
      end else begin
        r       = '0;
        r.phase = PH_UNCOVERED;
      end
      return r;
    endfunction

    function void take_hour(hour_t hr);
      expected_q.push_back(predict(hr));
    endfunction

    task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word", '0, {got.alpha, got.blue, got.green, got.red});
        return;
      end
      want = expected_q.pop_front();
      phase_hits[want.phase]++;
      checked++;
      if (got.red   !== want.red)   report_mismatch("red",   32'(want.red),   32'(got.red));
      if (got.green !== want.green) report_mismatch("green", 32'(want.green), 32'(got.green));
      if (got.blue  !== want.blue)  report_mismatch("blue",  32'(want.blue),  32'(got.blue));
      if (got.alpha !== want.alpha) report_mismatch("alpha", 32'(want.alpha), 32'(got.alpha));
      if (got.phase !== want.phase) report_mismatch("phase", 32'(want.phase), 32'(got.phase));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [PHASE_W-1:0]     out_tuser;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  // knobs for the sender and the receiver, and a count of loaded settings
  bit hold_request;
  bit quiet_tail;
  int idle_pct;
  int stall_pct;
  int settings_loaded;

  colour_ramp_checker chk = new();

  time_of_day_colour_ramp dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Both handshakes are sampled here at the rising edge; the input side is
  // noted first so a zero-latency path could never look like a stray word.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) chk.take_hour(in_tdata[HOUR_W-1:0]);
      if (out_tvalid && out_tready) chk.check_result(result_t'({out_tuser, out_tdata}));
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none in the tail.
  initial begin
    int gap;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else if (!quiet_tail && stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
        gap = $urandom_range(1, 14);
        out_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Safety net against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("time_of_day_colour_ramp_test NOT OK");
    $finish;
  end

  // All driver tasks are entered and left at a falling edge.
  task automatic send_hour(hour_t hr);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(hr);  // padding bits stay zero
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic pause_sender(int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic send_with_gaps(hour_t hr);
    send_hour(hr);
    if (!quiet_tail && idle_pct > 0 && $urandom_range(1, 100) <= idle_pct)
      pause_sender($urandom_range(1, 14));
  endtask

  // Sender goes quiet until every colour word is back, then the pipe drains.
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (chk.expected_q.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  // Write enable stays high across a batch; load_settings lowers it at the end.
  task automatic cfg_write(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    chk.write_reg(idx, value);
    @(negedge clk);
  endtask

  // pad: junk above the hour width, must be ignored by the block
  task automatic load_settings(cfg_t s, logic [CFG_DATA_W-1:0] pad);
    logic [CFG_DATA_W-1:0] junk;
    junk = pad & HOUR_PAD_BITS;
    cfg_write(REG_SUNRISE_BEGIN,  junk | CFG_DATA_W'(s.sunrise_begin));
    cfg_write(REG_SUNRISE_END,    junk | CFG_DATA_W'(s.sunrise_end));
    cfg_write(REG_SUNSET_BEGIN,   junk | CFG_DATA_W'(s.sunset_begin));
    cfg_write(REG_SUNSET_FINISH,  junk | CFG_DATA_W'(s.sunset_finish));
    cfg_write(REG_NIGHT_COLOUR,   s.night_colour);
    cfg_write(REG_SUNRISE_COLOUR, s.sunrise_colour);
    cfg_write(REG_DAY_COLOUR,     s.day_colour);
    cfg_write(REG_SUNSET_COLOUR,  s.sunset_colour);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  function automatic int pick_window_len();
    // short windows now and then, zero length included
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 8);
    return $urandom_range(9, 1500);
  endfunction

  function automatic colour_t pick_colour();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return colour_t'($urandom);
    endcase
  endfunction

  function automatic int clamp_day(int v);
    return (v > DAY_END) ? DAY_END : v;
  endfunction

  // Mostly ordered edges; disordered ones give empty or overlapping windows.
  function automatic cfg_t random_settings(bit disordered);
    cfg_t s;
    int   a, b, c, d;
    if (disordered) begin
      a = $urandom_range(0, DAY_END);
      b = $urandom_range(0, DAY_END);
      c = $urandom_range(0, DAY_END);
      d = $urandom_range(0, DAY_END);
    end else begin
      a = $urandom_range(0, 2500);
      b = clamp_day(a + pick_window_len());
      c = clamp_day(b + $urandom_range(0, 1200));
      d = clamp_day(c + pick_window_len());
    end
    s.sunrise_begin  = hour_t'(a);
    s.sunrise_end    = hour_t'(b);
    s.sunset_begin   = hour_t'(c);
    s.sunset_finish  = hour_t'(d);
    s.night_colour   = pick_colour();
    s.sunrise_colour = pick_colour();
    s.day_colour     = pick_colour();
    s.sunset_colour  = pick_colour();
    return s;
  endfunction

  // Hours aimed at edges, window interiors and midpoints, plus plain noise.
  function automatic hour_t pick_hour();
    int h, anchor, b, e;
    if ($urandom_range(0, 1)) begin
      b = chk.regs.sunrise_begin;
      e = chk.regs.sunrise_end;
    end else begin
      b = chk.regs.sunset_begin;
      e = chk.regs.sunset_finish;
    end
    case ($urandom_range(0, 9))
      0, 1, 2: h = $urandom_range(0, DAY_END);
      3, 4, 5: begin
        case ($urandom_range(0, 3))
          0:       anchor = chk.regs.sunrise_begin;
          1:       anchor = chk.regs.sunrise_end;
          2:       anchor = chk.regs.sunset_begin;
          default: anchor = chk.regs.sunset_finish;
        endcase
        h = anchor + $urandom_range(0, 6) - 3;
      end
      6, 7:    h = $urandom_range(e, b);
      8:       h = (b + e) / 2 + $urandom_range(0, 4) - 2;
      default: h = $urandom_range(0, HOUR_MAX);
    endcase
    if (h < 0) h = 0;
    if (h > HOUR_MAX) h = HOUR_MAX;
    return hour_t'(h);
  endfunction

  initial begin
    cfg_t s;
    int   pct_pick;
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    hold_request    = 1'b0;
    quiet_tail      = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    settings_loaded = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values: all colours zero, so only the phase code tells the edges.
    send_hour(0);
    send_hour(1280);
    send_hour(2048);
    send_hour(4352);
    send_hour(5120);
    send_hour(hour_t'(DAY_END));
    wait_all_results();

    // Default edges, extreme colours, junk above the hour width on every edge.
    s.sunrise_begin  = RST_SUNRISE_BEGIN;
    s.sunrise_end    = RST_SUNRISE_END;
    s.sunset_begin   = RST_SUNSET_BEGIN;
    s.sunset_finish  = RST_SUNSET_FINISH;
    s.night_colour   = 32'h1020_30FF;
    s.sunrise_colour = 32'hFFFF_FFFF;
    s.day_colour     = 32'h0000_0000;
    s.sunset_colour  = 32'hFF80_01C0;
    load_settings(s, '1);
    send_hour(1279);     // last night hour
    send_hour(1280);     // window start, full ramp toward night
    send_hour(1663);
    send_hour(1664);     // exact midpoint, peak colour
    send_hour(1665);
    send_hour(2048);     // window end, ramp toward day
    send_hour(2049);
    send_hour(4736);     // sunset midpoint
    send_hour(5120);
    send_hour(5121);
    send_hour(hour_t'(HOUR_MAX)); // all bits set
    wait_all_results();

    // Zero-length windows at both ends of the day.
    s.sunrise_begin  = '0;
    s.sunrise_end    = '0;
    s.sunset_begin   = hour_t'(DAY_END);
    s.sunset_finish  = hour_t'(DAY_END);
    s.night_colour   = 32'hFFFF_FFFF;
    s.sunrise_colour = 32'h00FF_00FF;
    s.day_colour     = 32'h7F7F_7F7F;
    s.sunset_colour  = 32'h0102_0304;
    load_settings(s, '0);
    send_hour(0);
    send_hour(1);
    send_hour(hour_t'(DAY_END - 1));
    send_hour(hour_t'(DAY_END));
    send_hour(hour_t'(DAY_END + 1));
    wait_all_results();

    // Both windows reversed: neither covers any hour.
    s.sunrise_begin  = hour_t'(3000);
    s.sunrise_end    = hour_t'(1000);
    s.sunset_begin   = hour_t'(5000);
    s.sunset_finish  = hour_t'(4000);
    s.night_colour   = 32'hA5A5_5A5A;
    s.sunrise_colour = 32'h1234_5678;
    s.day_colour     = 32'h8765_4321;
    s.sunset_colour  = 32'hC3C3_3C3C;
    load_settings(s, '0);
    send_hour(2000);
    send_hour(3500);
    send_hour(4500);

    // Random part: eight settings, fifty hours each, thirty more in the third.
    for (int ph = 0; ph < 8; ph++) begin
      wait_all_results();
      load_settings(random_settings(ph % 3 == 2), $urandom);
      pct_pick = $urandom_range(0, 3);
      idle_pct  = (pct_pick == 0) ? 0 : pct_pick * 15;
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
      quiet_tail = (ph == 7);  // last stretch runs at full rate
      for (int k = 0; k < 50; k++) begin
        if (ph == 2 && k == 10) begin
          // Receiver holds off while words keep coming: pipe fills, input stalls.
          hold_request = 1'b1;
          repeat (30) send_hour(pick_hour());
          wait_all_results();
        end
        send_with_gaps(pick_hour());
      end
    end
    wait_all_results();

    $display("checked %0d colour words under %0d register settings", chk.checked,
             settings_loaded);
    $display("by phase: night %0d, sunrise %0d, day %0d, sunset %0d", chk.phase_hits[0],
             chk.phase_hits[1], chk.phase_hits[2], chk.phase_hits[3]);
    if (chk.errors == 0) begin
      $display("time_of_day_colour_ramp_test OK");
    end else begin
      $display("time_of_day_colour_ramp_test NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/tdcr_pkg.sv
rtl/tdcr_select.sv
rtl/tdcr_div_stage.sv
rtl/tdcr_blend.sv
rtl/time_of_day_colour_ramp.sv
verif/time_of_day_colour_ramp_test.sv
